>>> rtl/tmr_pkg.sv
// trackball motion report: shared types, constants and the speed curve
// used by the controller, the datapath, the top level and the port checker
// no dependencies
package tmr_pkg;

  // field widths
  localparam int DELTA_W    = 9;
  localparam int CODE_W     = 8;
  localparam int REQ_W      = 2;
  localparam int MOVE_W     = 12;
  localparam int SCROLL_W   = 9;
  localparam int EVT_W      = 2;
  localparam int SPEED_W    = 7;
  localparam int FACTOR_W   = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 5;

  // stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // output word field positions
  localparam int OUT_VALID_LSB  = 0;
  localparam int OUT_MOVE_X_LSB = 1;
  localparam int OUT_MOVE_Y_LSB = 13;
  localparam int OUT_SCR_X_LSB  = 25;
  localparam int OUT_SCR_Y_LSB  = 34;
  localparam int OUT_EVT_LSB    = 43;
  localparam int OUT_MODE_LSB   = 45;
  localparam int OUT_USED_W     = 46;

  // scroll divider: dividend magnitude bits, bits resolved per cycle
  localparam int DIV_W     = 10;
  localparam int DIV_STEP  = 5;
  localparam int DIV_STEPS = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // button codes and limits
  localparam logic [CODE_W-1:0]   CODE_PRESS      = 8'h80;
  localparam logic [CODE_W-1:0]   CODE_RELEASE    = 8'h01;
  localparam logic [FACTOR_W-1:0] SPEED_GAIN_MAX  = 5'd16;
  localparam logic [SPEED_W-1:0]  SPEED_SAT       = 7'd127;
  localparam logic [SCROLL_W-1:0] SCROLL_POS_MAX  = 9'd255;

  // register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SPEED_GAIN      = 3'd0,
    CFG_INVERT_MOVE_X   = 3'd1,
    CFG_INVERT_MOVE_Y   = 3'd2,
    CFG_WHEEL_DIV       = 3'd3,
    CFG_INVERT_SCROLL_X = 3'd4,
    CFG_INVERT_SCROLL_Y = 3'd5,
    CFG_AXIS_XCHG       = 3'd6,
    CFG_START_MODE      = 3'd7
  } cfg_idx_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_MOVE   = 2'd0,
    REQ_SCROLL = 2'd1,
    REQ_TOGGLE = 2'd2,
    REQ_NONE   = 2'd3
  } mode_req_t;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE    = 2'd0,
    EVT_PRESS   = 2'd1,
    EVT_RELEASE = 2'd2
  } btn_evt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // pointer speed curve over the delta magnitude
  function automatic logic [SPEED_W-1:0] speed_lut(input logic [DELTA_W-1:0] mag);
    logic [SPEED_W-1:0] r;
    case (mag)
      9'd0:    r = 7'd0;
      9'd1:    r = 7'd1;
      9'd2:    r = 7'd4;
      9'd3:    r = 7'd8;
      9'd4:    r = 7'd18;
      9'd5:    r = 7'd32;
      9'd6:    r = 7'd50;
      9'd7:    r = 7'd72;
      9'd8:    r = 7'd98;
      default: r = SPEED_SAT;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/tmr_ctrl.sv
// trackball motion report: sequencing state machine
// steps the datapath through load, divide and result hand-off
// depends on tmr_pkg
module tmr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  tmr_pkg::dp_stat_t stat,
  output tmr_pkg::dp_cmd_t  cmd
);

  tmr_pkg::state_t                state;
  tmr_pkg::state_t                state_next;
  logic [tmr_pkg::DIV_CNT_W-1:0]  cnt;
  logic                           last_step;

  assign last_step = (cnt == tmr_pkg::DIV_CNT_W'(tmr_pkg::DIV_STEPS - 1));

  // state and divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmr_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == tmr_pkg::ST_CALC) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmr_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tmr_pkg::ST_CALC;
      end
      tmr_pkg::ST_CALC: begin
        if (last_step) state_next = tmr_pkg::ST_DONE;
      end
      tmr_pkg::ST_DONE: begin
        if (stat.out_free) state_next = tmr_pkg::ST_IDLE;
      end
      default: state_next = tmr_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      tmr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      tmr_pkg::ST_CALC: begin
        cmd.step = 1'b1;
      end
      tmr_pkg::ST_DONE: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/tmr_dp.sv
// trackball motion report: datapath with registers, mode and button flags,
// speed curve, move multiply, two-lane scroll divider and output register
// depends on tmr_pkg
module tmr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tmr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [tmr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [tmr_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                s_tuser,
  input  tmr_pkg::dp_cmd_t                    cmd,
  output tmr_pkg::dp_stat_t                   stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tmr_pkg::OUT_DATA_W-1:0]      m_tdata
);

  typedef struct packed {
    logic [tmr_pkg::DIV_W-1:0]    q;
    logic [tmr_pkg::FACTOR_W-1:0] r;
  } div_st_t;

  // several restoring divide bits on one lane
  function automatic div_st_t div_step(input div_st_t s, input logic [tmr_pkg::FACTOR_W-1:0] d);
    div_st_t                      o;
    logic [tmr_pkg::FACTOR_W:0]   t;
    o = s;
    for (int i = 0; i < tmr_pkg::DIV_STEP; i++) begin
      t   = {o.r, o.q[tmr_pkg::DIV_W-1]};
      o.q = {o.q[tmr_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t      = t - {1'b0, d};
        o.q[0] = 1'b1;
      end
      o.r = t[tmr_pkg::FACTOR_W-1:0];
    end
    return o;
  endfunction

  // configuration registers
  logic [tmr_pkg::FACTOR_W-1:0] speed_gain;
  logic                         inv_move_x;
  logic                         inv_move_y;
  logic [tmr_pkg::FACTOR_W-1:0] wheel_div;
  logic                         inv_scroll_x;
  logic                         inv_scroll_y;
  logic                         axis_xchg;

  // block state
  logic cur_mode;
  logic press_rep;
  logic release_rep;

  // input fields
  logic [tmr_pkg::DELTA_W-1:0] in_dx;
  logic [tmr_pkg::DELTA_W-1:0] in_dy;
  logic [tmr_pkg::CODE_W-1:0]  in_code;
  tmr_pkg::mode_req_t          in_req;
  logic                        in_sample;

  logic [tmr_pkg::DELTA_W-1:0]  ax;
  logic [tmr_pkg::DELTA_W-1:0]  ay;
  logic [tmr_pkg::DELTA_W-1:0]  mag_x;
  logic [tmr_pkg::DELTA_W-1:0]  mag_y;
  logic [tmr_pkg::SPEED_W-1:0]  spd_x;
  logic [tmr_pkg::SPEED_W-1:0]  spd_y;
  logic [tmr_pkg::FACTOR_W-1:0] fmag;
  logic [tmr_pkg::FACTOR_W-1:0] dmag;
  logic                         motion;
  logic                         mode_next;
  tmr_pkg::btn_evt_t            evt_next;

  // item registers
  logic                         r_sample;
  logic                         r_motion;
  logic                         r_mode;
  tmr_pkg::btn_evt_t            r_evt;
  logic signed [7:0]            spx;
  logic signed [7:0]            spy;
  logic signed [5:0]            fx;
  logic signed [5:0]            fy;
  logic                         neg_x;
  logic                         neg_y;
  logic [tmr_pkg::FACTOR_W-1:0] div_d;
  div_st_t                      lane_x;
  div_st_t                      lane_y;

  // result logic
  logic signed [13:0]            prod_x;
  logic signed [13:0]            prod_y;
  logic [tmr_pkg::SCROLL_W-1:0]  qmag_x;
  logic [tmr_pkg::SCROLL_W-1:0]  qmag_y;
  logic [tmr_pkg::SCROLL_W-1:0]  scr_x;
  logic [tmr_pkg::SCROLL_W-1:0]  scr_y;
  logic [tmr_pkg::MOVE_W-1:0]    mov_x;
  logic [tmr_pkg::MOVE_W-1:0]    mov_y;
  logic                          report;
  logic                          do_move;
  logic                          do_scroll;

  // unpack the input word
  assign in_dx     = s_tdata[8:0];
  assign in_dy     = s_tdata[17:9];
  assign in_code   = s_tdata[25:18];
  assign in_req    = tmr_pkg::mode_req_t'(s_tdata[27:26]);
  assign in_sample = ~s_tuser;

  // axis swap, magnitudes and speed curve
  assign ax     = axis_xchg ? in_dy : in_dx;
  assign ay     = axis_xchg ? in_dx : in_dy;
  assign mag_x  = ax[8] ? (~ax + 9'd1) : ax;
  assign mag_y  = ay[8] ? (~ay + 9'd1) : ay;
  assign spd_x  = tmr_pkg::speed_lut(mag_x);
  assign spd_y  = tmr_pkg::speed_lut(mag_y);
  assign motion = (in_dx != '0) || (in_dy != '0);
  assign fmag   = (speed_gain > tmr_pkg::SPEED_GAIN_MAX) ? tmr_pkg::SPEED_GAIN_MAX
                                                         : speed_gain;
  assign dmag   = (wheel_div == '0) ? 5'd1 : wheel_div;

  // mode request decode
  always_comb begin
    mode_next = cur_mode;
    if (!in_sample) begin
      unique case (in_req)
        tmr_pkg::REQ_MOVE:   mode_next = 1'b0;
        tmr_pkg::REQ_SCROLL: mode_next = 1'b1;
        tmr_pkg::REQ_TOGGLE: mode_next = ~cur_mode;
        tmr_pkg::REQ_NONE:   mode_next = cur_mode;
        default:             mode_next = cur_mode;
      endcase
    end
  end

  // button event with repeat suppression
  always_comb begin
    evt_next = tmr_pkg::EVT_NONE;
    if (in_sample && in_code == tmr_pkg::CODE_PRESS && !press_rep) begin
      evt_next = tmr_pkg::EVT_PRESS;
    end else if (in_sample && in_code == tmr_pkg::CODE_RELEASE && !release_rep) begin
      evt_next = tmr_pkg::EVT_RELEASE;
    end
  end

  // configuration writes, mode and button flags
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain     <= 5'd1;
      inv_move_x     <= 1'b0;
      inv_move_y     <= 1'b0;
      wheel_div      <= 5'd1;
      inv_scroll_x   <= 1'b0;
      inv_scroll_y   <= 1'b0;
      axis_xchg      <= 1'b0;
      cur_mode       <= 1'b0;
      press_rep      <= 1'b0;
      release_rep    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (tmr_pkg::cfg_idx_t'(cfg_addr))
          tmr_pkg::CFG_SPEED_GAIN:      speed_gain     <= cfg_data;
          tmr_pkg::CFG_INVERT_MOVE_X:   inv_move_x     <= cfg_data[0];
          tmr_pkg::CFG_INVERT_MOVE_Y:   inv_move_y     <= cfg_data[0];
          tmr_pkg::CFG_WHEEL_DIV:       wheel_div      <= cfg_data;
          tmr_pkg::CFG_INVERT_SCROLL_X: inv_scroll_x   <= cfg_data[0];
          tmr_pkg::CFG_INVERT_SCROLL_Y: inv_scroll_y   <= cfg_data[0];
          tmr_pkg::CFG_AXIS_XCHG:       axis_xchg      <= cfg_data[0];
          tmr_pkg::CFG_START_MODE:      cur_mode       <= cfg_data[0];
          default:                      axis_xchg      <= axis_xchg;
        endcase
      end else if (cmd.load) begin
        cur_mode <= mode_next;
        if (evt_next == tmr_pkg::EVT_PRESS) begin
          press_rep   <= 1'b1;
          release_rep <= 1'b0;
        end else if (evt_next == tmr_pkg::EVT_RELEASE) begin
          press_rep   <= 1'b0;
          release_rep <= 1'b1;
        end
      end
    end
  end

  // item operands and divider lanes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_sample <= in_sample;
      r_motion <= motion;
      r_mode   <= mode_next;
      r_evt    <= evt_next;
      spx      <= ax[8] ? 8'(~{1'b0, spd_x} + 8'd1) : {1'b0, spd_x};
      spy      <= ay[8] ? 8'(~{1'b0, spd_y} + 8'd1) : {1'b0, spd_y};
      fx       <= inv_move_x ? 6'(~{1'b0, fmag} + 6'd1) : {1'b0, fmag};
      fy       <= inv_move_y ? 6'(~{1'b0, fmag} + 6'd1) : {1'b0, fmag};
      neg_x    <= ax[8] ^ inv_scroll_x;
      neg_y    <= ay[8] ^ ~inv_scroll_y;
      div_d    <= dmag;
      lane_x   <= '{q: {1'b0, mag_x}, r: '0};
      lane_y   <= '{q: {1'b0, mag_y}, r: '0};
    end else if (cmd.step) begin
      lane_x <= div_step(lane_x, div_d);
      lane_y <= div_step(lane_y, div_d);
    end
  end

  // move products
  assign prod_x = spx * fx;
  assign prod_y = spy * fy;

  // scroll quotients with sign and positive saturation
  assign qmag_x = (!neg_x && lane_x.q > 10'd255) ? tmr_pkg::SCROLL_POS_MAX : lane_x.q[8:0];
  assign qmag_y = (!neg_y && lane_y.q > 10'd255) ? tmr_pkg::SCROLL_POS_MAX : lane_y.q[8:0];
  assign scr_x  = neg_x ? (~qmag_x + 9'd1) : qmag_x;
  assign scr_y  = neg_y ? (~qmag_y + 9'd1) : qmag_y;

  // result selection
  assign do_move   = r_sample && r_motion && !r_mode;
  assign do_scroll = r_sample && r_motion && r_mode;
  assign report    = r_sample && (r_motion || r_evt != tmr_pkg::EVT_NONE);
  assign mov_x     = do_move ? prod_x[11:0] : '0;
  assign mov_y     = do_move ? prod_y[11:0] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {2'b00, r_mode, r_evt,
                  do_scroll ? scr_y : 9'd0,
                  do_scroll ? scr_x : 9'd0,
                  mov_y, mov_x, report};
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

endmodule

>>> rtl/trackball_motion_report_top.sv
// trackball motion report: top level
// joins the controller (tmr_ctrl) and the datapath (tmr_dp); uses tmr_pkg
//
//  channel  | direction | handshake          | word contents (lsb first)
//  ---------+-----------+--------------------+---------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: delta_x, delta_y,
//           |           |                    | button_code, mode_request; tuser: operation
//  m_*      | out       | m_tvalid/m_tready  | tdata: report_valid, move_x, move_y,
//           |           |                    | scroll_x, scroll_y, button_event, mode
//  cfg_*    | in        | cfg_we, no stall   | register index and data
//
// a word is accepted, then resolved by the scroll divider (five quotient bits per
// cycle on both axes), and then loads the output register. the next word is taken
// while a result still waits in the output register; a stalled output holds the
// block in its done state. rst is synchronous and returns the configuration
// registers, the mode and the button flags to their reset values.
module trackball_motion_report_top (
  input  logic                            clk,
  input  logic                            rst,
  // delta_x, delta_y, button_code, mode_request
  input  logic [tmr_pkg::IN_DATA_W-1:0]   s_tdata,
  // operation
  input  logic                            s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // report_valid, move_x, move_y, scroll_x, scroll_y, button_event,
  // scroll_mode_active
  output logic [tmr_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [tmr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tmr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tmr_pkg::dp_cmd_t  cmd;
  tmr_pkg::dp_stat_t stat;

  // sequencer
  tmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  tmr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/tmr_chk.sv
// trackball motion report: port checker and its bind to the top level
// watches the stream ports only; uses tmr_pkg for field positions
module tmr_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [tmr_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // an accepted word keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after accept");

  // a word without a report carries no motion and no button event
  a_quiet_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[tmr_pkg::OUT_VALID_LSB]
      |-> m_tdata[tmr_pkg::OUT_MODE_LSB-1:tmr_pkg::OUT_MOVE_X_LSB] == '0)
    else $error("motion or event without report");

  // a button event always comes with a report, and its code is defined
  a_event_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[tmr_pkg::OUT_EVT_LSB+1:tmr_pkg::OUT_EVT_LSB] != 2'b00
      |-> m_tdata[tmr_pkg::OUT_VALID_LSB]
          && m_tdata[tmr_pkg::OUT_EVT_LSB+1:tmr_pkg::OUT_EVT_LSB] != 2'b11)
    else $error("bad button event");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word out of reset");

endmodule

bind trackball_motion_report_top tmr_chk u_chk (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for trackball_motion_report_top: stream driver, result monitor
// and an in-bench predictor of speed curve, scroll division and button events
// depends on tmr_pkg and trackball_motion_report_top
module testbench;

  localparam logic MODE_MOVE   = 1'b0;
  localparam logic MODE_SCROLL = 1'b1;
  localparam int   HOLD_CYCLES = 400;
  localparam int   PHASES      = 8;
  localparam int   PHASE_ITEMS = 66;

  typedef struct {
    logic                                op;
    logic signed [tmr_pkg::DELTA_W-1:0]  dx;
    logic signed [tmr_pkg::DELTA_W-1:0]  dy;
    logic [tmr_pkg::CODE_W-1:0]          code;
    tmr_pkg::mode_req_t                  req;
  } sample_t;

  typedef struct {
    logic                                 valid;
    logic signed [tmr_pkg::MOVE_W-1:0]    mx;
    logic signed [tmr_pkg::MOVE_W-1:0]    my;
    logic signed [tmr_pkg::SCROLL_W-1:0]  sx;
    logic signed [tmr_pkg::SCROLL_W-1:0]  sy;
    tmr_pkg::btn_evt_t                    evt;
    logic                                 mode;
  } report_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic [tmr_pkg::IN_DATA_W-1:0]    s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [tmr_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [tmr_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [tmr_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  sample_t sample_q[$];
  report_t report_q[$];
  sample_t cur_sample;
  int      err_count = 0;
  int      send_idle_pct = 0;
  int      rcv_idle_pct = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  // predictor copy of registers and state
  int   mf, sd;
  logic imx, imy, isx, isy, swp;
  logic mode_now, press_seen, release_seen;

  trackball_motion_report_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // pointer speed curve with the sign restored
  function automatic int speed_curve(input int v);
    int mag;
    int r;
    mag = (v < 0) ? -v : v;
    case (mag)
      0: r = 0;
      1: r = 1;
      2: r = 4;
      3: r = 8;
      4: r = 18;
      5: r = 32;
      6: r = 50;
      7: r = 72;
      8: r = 98;
      default: r = 127;
    endcase
    return (v < 0) ? -r : r;
  endfunction

  function automatic int clamp_scroll(input int q);
    if (q > 255) return 255;
    if (q < -256) return -256;
    return q;
  endfunction

  // expected report for one accepted word, advances mode and button flags
  task automatic compute_report(input sample_t it);
    report_t r;
    int dx, dy, t, f, d;
    r = '{valid: 1'b0, mx: '0, my: '0, sx: '0, sy: '0, evt: tmr_pkg::EVT_NONE, mode: 1'b0};
    if (it.op) begin
      case (it.req)
        tmr_pkg::REQ_MOVE:   mode_now = MODE_MOVE;
        tmr_pkg::REQ_SCROLL: mode_now = MODE_SCROLL;
        tmr_pkg::REQ_TOGGLE: mode_now = ~mode_now;
        default: ;
      endcase
    end else begin
      dx = it.dx;
      dy = it.dy;
      if (dx != 0 || dy != 0) begin
        if (swp) begin
          t = dx;
          dx = dy;
          dy = t;
        end
        if (mode_now == MODE_MOVE) begin
          f = (mf > 16) ? 16 : mf;
          r.mx = tmr_pkg::MOVE_W'(speed_curve(dx) * (imx ? -f : f));
          r.my = tmr_pkg::MOVE_W'(speed_curve(dy) * (imy ? -f : f));
        end else begin
          d = (sd == 0) ? 1 : sd;
          r.sx = tmr_pkg::SCROLL_W'(clamp_scroll(dx / (isx ? -d : d)));
          r.sy = tmr_pkg::SCROLL_W'(clamp_scroll(dy / (isy ? d : -d)));
        end
        r.valid = 1'b1;
      end
      if (it.code == tmr_pkg::CODE_PRESS && !press_seen) begin
        press_seen = 1'b1;
        release_seen = 1'b0;
        r.evt = tmr_pkg::EVT_PRESS;
        r.valid = 1'b1;
      end else if (it.code == tmr_pkg::CODE_RELEASE && !release_seen) begin
        press_seen = 1'b0;
        release_seen = 1'b1;
        r.evt = tmr_pkg::EVT_RELEASE;
        r.valid = 1'b1;
      end
    end
    r.mode = mode_now;
    report_q.push_back(r);
  endtask

  // stream driver: accepted words go to the predictor, next word from the queue
  always @(posedge clk) begin
    sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) compute_report(cur_sample);
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_q.pop_front();
          cur_sample <= nxt;
          s_tdata <= {4'b0, nxt.req, nxt.code, nxt.dy, nxt.dx};
          s_tuser <= nxt.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // receiver with random and long stalls, result checker
  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
      if (m_tvalid && m_tready) begin
        if (report_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word, expected none actual %h", $time, m_tdata);
        end else begin
          want = report_q.pop_front();
          check_field("report_valid", want.valid, m_tdata[tmr_pkg::OUT_VALID_LSB]);
          check_field("move_x", want.mx,
                      $signed(m_tdata[tmr_pkg::OUT_MOVE_X_LSB +: tmr_pkg::MOVE_W]));
          check_field("move_y", want.my,
                      $signed(m_tdata[tmr_pkg::OUT_MOVE_Y_LSB +: tmr_pkg::MOVE_W]));
          check_field("scroll_x", want.sx,
                      $signed(m_tdata[tmr_pkg::OUT_SCR_X_LSB +: tmr_pkg::SCROLL_W]));
          check_field("scroll_y", want.sy,
                      $signed(m_tdata[tmr_pkg::OUT_SCR_Y_LSB +: tmr_pkg::SCROLL_W]));
          check_field("button_event", want.evt,
                      m_tdata[tmr_pkg::OUT_EVT_LSB +: tmr_pkg::EVT_W]);
          check_field("scroll_mode_active", want.mode, m_tdata[tmr_pkg::OUT_MODE_LSB]);
          check_field("padding", 0, m_tdata[tmr_pkg::OUT_DATA_W-1:tmr_pkg::OUT_USED_W]);
        end
      end
    end
  end

  function automatic sample_t sensor(input int dx, input int dy, input int code);
    sample_t s;
    s.op = 1'b0;
    s.dx = tmr_pkg::DELTA_W'(dx);
    s.dy = tmr_pkg::DELTA_W'(dy);
    s.code = tmr_pkg::CODE_W'(code);
    s.req = tmr_pkg::mode_req_t'($urandom_range(3));
    return s;
  endfunction

  function automatic sample_t request(input tmr_pkg::mode_req_t req);
    sample_t s;
    s.op = 1'b1;
    s.dx = tmr_pkg::DELTA_W'($urandom);
    s.dy = tmr_pkg::DELTA_W'($urandom);
    s.code = tmr_pkg::CODE_W'($urandom);
    s.req = req;
    return s;
  endfunction

  // deltas lean toward the table range and the extremes
  function automatic int rand_delta();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return $urandom_range(18) - 9;
    if (pick < 45) begin
      case ($urandom_range(3))
        0: return -256;
        1: return -255;
        2: return 255;
        default: return 0;
      endcase
    end
    return $urandom_range(511) - 256;
  endfunction

  function automatic sample_t rand_sample();
    int pick, code;
    if ($urandom_range(99) < 15) return request(tmr_pkg::mode_req_t'($urandom_range(3)));
    pick = $urandom_range(99);
    if (pick < 30) code = tmr_pkg::CODE_PRESS;
    else if (pick < 60) code = tmr_pkg::CODE_RELEASE;
    else code = $urandom_range(255);
    if ($urandom_range(9) == 0) return sensor(0, 0, code);
    return sensor(rand_delta(), rand_delta(), code);
  endfunction

  task automatic write_reg(input tmr_pkg::cfg_idx_t idx, input int val);
    case (idx)
      tmr_pkg::CFG_SPEED_GAIN:      mf = val & 31;
      tmr_pkg::CFG_INVERT_MOVE_X:   imx = val[0];
      tmr_pkg::CFG_INVERT_MOVE_Y:   imy = val[0];
      tmr_pkg::CFG_WHEEL_DIV:       sd = val & 31;
      tmr_pkg::CFG_INVERT_SCROLL_X: isx = val[0];
      tmr_pkg::CFG_INVERT_SCROLL_Y: isy = val[0];
      tmr_pkg::CFG_AXIS_XCHG:       swp = val[0];
      tmr_pkg::CFG_START_MODE:      mode_now = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= tmr_pkg::CFG_DATA_W'(val);
  endtask

  // sampled away from the active edge so that queue and handshake have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || report_q.size() != 0);
  endtask

  // register settings per phase, extremes and out-of-range values included
  int mf_set[PHASES]  = '{16, 0, 31, 1, 7, 17, 3, 12};
  int imx_set[PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};
  int imy_set[PHASES] = '{0, 1, 1, 0, 0, 1, 1, 0};
  int sd_set[PHASES]  = '{1, 16, 0, 31, 3, 5, 2, 7};
  int isx_set[PHASES] = '{1, 0, 0, 1, 1, 0, 1, 0};
  int isy_set[PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1};
  int swp_set[PHASES] = '{0, 1, 1, 0, 1, 0, 0, 1};
  int sm_set[PHASES]  = '{1, 0, 1, 0, 0, 1, 0, 1};

  initial begin
    mf = 1; sd = 1;
    imx = 1'b0; imy = 1'b0; isx = 1'b0; isy = 1'b0; swp = 1'b0;
    mode_now = MODE_MOVE; press_seen = 1'b0; release_seen = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset settings
    send_idle_pct = 20;
    rcv_idle_pct = 71;
    sample_q.push_back(sensor(0, 0, 0));
    sample_q.push_back(sensor(1, -1, tmr_pkg::CODE_PRESS));
    sample_q.push_back(sensor(0, 0, tmr_pkg::CODE_PRESS));
    sample_q.push_back(sensor(0, 0, tmr_pkg::CODE_RELEASE));
    sample_q.push_back(sensor(0, 0, tmr_pkg::CODE_RELEASE));
    sample_q.push_back(sensor(255, -256, 8'h7f));
    sample_q.push_back(sensor(-256, 255, 8'hff));
    sample_q.push_back(sensor(8, -8, 0));
    sample_q.push_back(sensor(9, -9, tmr_pkg::CODE_PRESS));
    sample_q.push_back(sensor(2, 3, 0));
    sample_q.push_back(sensor(-4, 5, 0));
    sample_q.push_back(sensor(6, -7, tmr_pkg::CODE_RELEASE));
    sample_q.push_back(request(tmr_pkg::REQ_SCROLL));
    sample_q.push_back(sensor(-256, -256, 0));
    sample_q.push_back(sensor(255, 1, 8'h81));
    sample_q.push_back(sensor(0, 0, tmr_pkg::CODE_PRESS));
    sample_q.push_back(request(tmr_pkg::REQ_TOGGLE));
    sample_q.push_back(request(tmr_pkg::REQ_NONE));
    sample_q.push_back(sensor(3, 0, tmr_pkg::CODE_RELEASE));
    sample_q.push_back(request(tmr_pkg::REQ_MOVE));
    sample_q.push_back(request(tmr_pkg::REQ_TOGGLE));
    sample_q.push_back(sensor(0, -1, tmr_pkg::CODE_PRESS));
    sample_q.push_back(request(tmr_pkg::REQ_MOVE));
    wait_drained();

    // random phases over the register settings
    for (int p = 0; p < PHASES; p++) begin
      write_reg(tmr_pkg::CFG_SPEED_GAIN, mf_set[p]);
      write_reg(tmr_pkg::CFG_INVERT_MOVE_X, imx_set[p]);
      write_reg(tmr_pkg::CFG_INVERT_MOVE_Y, imy_set[p]);
      write_reg(tmr_pkg::CFG_WHEEL_DIV, sd_set[p]);
      write_reg(tmr_pkg::CFG_INVERT_SCROLL_X, isx_set[p]);
      write_reg(tmr_pkg::CFG_INVERT_SCROLL_Y, isy_set[p]);
      write_reg(tmr_pkg::CFG_AXIS_XCHG, swp_set[p]);
      write_reg(tmr_pkg::CFG_START_MODE, sm_set[p]);
      @(posedge clk);
      cfg_we <= 1'b0;
      if (p < 3) begin
        send_idle_pct = 20;
        rcv_idle_pct = 71;
      end else if (p < 6) begin
        send_idle_pct = 71;
        rcv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) sample_q.push_back(rand_sample());
      // long output stall while the sender keeps offering
      if (p == 1) hold_req++;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (report_q.size() != 0) begin
      err_count++;
      $display("%0t: reports left over, expected 0 actual %0d", $time, report_q.size());
    end
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tmr_pkg.sv
rtl/tmr_ctrl.sv
rtl/tmr_dp.sv
rtl/trackball_motion_report_top.sv
rtl/tmr_chk.sv
tb/testbench.sv
